[hw/rtl/lirs_pkg.sv]
// shared types, constants and handshake structs of the linear interpolation resampler
package lirs_pkg;

  // field and state widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned RateW    = 18;
  localparam int unsigned PhaseW   = 24;

  // upsampling limit and the cap on results caused by one input
  localparam int unsigned MaxRatio  = 16;
  localparam int unsigned ResultCap = ((2 * MaxRatio) < 32) ? (2 * MaxRatio) : 32;
  localparam int unsigned CountW    = $clog2(ResultCap + 1);

  // one quotient bit per divider step
  localparam int unsigned DivSteps  = SampleW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  // configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CfgSrcRate = 1'b0;
  localparam cfg_idx_t CfgDstRate = 1'b1;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [RateW-1:0]          rate_t;
  typedef logic [PhaseW-1:0]         phase_t;
  typedef logic [CountW-1:0]         count_t;

  // reset values of the rate registers
  localparam rate_t SrcRateRst = 18'd44100;
  localparam rate_t DstRateRst = 18'd8000;

  // request to the shared multiply and divide unit
  typedef struct packed {
    logic    start;
    sample_t a;
    sample_t b;
    rate_t   r;
    rate_t   d;
  } arith_req_t;

  // answer of the shared unit, done pulses for one cycle
  typedef struct packed {
    logic    done;
    sample_t quot;
  } arith_rsp_t;

endpackage

[hw/rtl/linear_interp_resampler_top.sv]
// top level of the linear interpolation resampler: rate registers and unit wiring
//
// Input samples arrive on a valid/ready channel (sample_in_i, end_of_stream_i);
// interpolated samples leave on a valid/ready channel (sample_out_o with
// last_of_run_o on the final result of each input and stream_done_o on the
// final result of a flagged last input). Rates are written through cfg_we_i,
// cfg_idx_i (0 source rate, 1 destination rate) and cfg_data_i; the user must
// write them only while idle, as the block itself does not enforce it. One input
// is worked on at a time; in_ready_o is low until all its results have been
// handed to the output register. Each interpolated result goes through a
// two-step shared multiply, a 16-step restoring divide and the hand-off; a
// repeated tail sample needs only the hand-off. Equal rates pass a sample
// straight through. The output register is one deep, behind a one-deep held
// result: a stalled receiver stops the sequencer when a new result finds both
// full, and nothing is lost.
// Reset clears the stream (no previous sample, phase zero) and sets the
// rates to 44100 and 8000.
module linear_interp_resampler_top (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [15:0]      sample_in_i,
  input  logic                    end_of_stream_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [15:0]      sample_out_o,
  output logic                    last_of_run_o,
  output logic                    stream_done_o,
  input  logic                    cfg_we_i,
  input  lirs_pkg::cfg_idx_t      cfg_idx_i,
  input  logic [17:0]             cfg_data_i
);

  lirs_pkg::rate_t      src_rate_q, dst_rate_q;
  lirs_pkg::rate_t      src_eff, dst_eff;
  lirs_pkg::arith_req_t arith_req;
  lirs_pkg::arith_rsp_t arith_rsp;

  // rate registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_rate_q <= lirs_pkg::SrcRateRst;
      dst_rate_q <= lirs_pkg::DstRateRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lirs_pkg::CfgSrcRate: src_rate_q <= cfg_data_i;
        lirs_pkg::CfgDstRate: dst_rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a zero rate reads as one
  assign src_eff = (src_rate_q == '0) ? lirs_pkg::rate_t'(1) : src_rate_q;
  assign dst_eff = (dst_rate_q == '0) ? lirs_pkg::rate_t'(1) : dst_rate_q;

  lirs_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_in_i    (sample_in_i),
    .end_of_stream_i(end_of_stream_i),
    .src_rate_i     (src_eff),
    .dst_rate_i     (dst_eff),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_out_o   (sample_out_o),
    .last_of_run_o  (last_of_run_o),
    .stream_done_o  (stream_done_o),
    .arith_req_o    (arith_req),
    .arith_rsp_i    (arith_rsp)
  );

  lirs_arith u_arith (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (arith_req),
    .rsp_o (arith_rsp)
  );

endmodule

[hw/rtl/lirs_arith.sv]
// shared multiply-accumulate and restoring divider for one interpolated sample
module lirs_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lirs_pkg::arith_req_t req_i,
  output lirs_pkg::arith_rsp_t rsp_o
);

  localparam int unsigned SampleW = lirs_pkg::SampleW;
  localparam int unsigned RateW   = lirs_pkg::RateW;
  localparam int unsigned ProdW   = (SampleW + 1) + (RateW + 1);

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_MULB = 2'd1;
  localparam logic [1:0] A_ABS  = 2'd2;
  localparam logic [1:0] A_DIV  = 2'd3;

  logic [1:0]                      st_q, st_d;
  logic signed [ProdW-1:0]         acc_q, acc_d;
  logic                            neg_q, neg_d;
  logic [RateW-1:0]                rem_q, rem_d;
  logic [SampleW-1:0]              lo_q, lo_d;
  logic [lirs_pkg::DivCntW-1:0]    cnt_q, cnt_d;
  logic                            done_q, done_d;
  lirs_pkg::sample_t               quot_q, quot_d;

  logic signed [SampleW:0]         op_x;
  logic signed [RateW:0]           op_y;
  logic signed [ProdW-1:0]         prod;
  logic [ProdW-1:0]                mag;
  logic [RateW:0]                  trial;
  logic                            fits;
  logic [RateW-1:0]                rem_next;
  logic [SampleW-1:0]              lo_next;

  // the one multiplier, operands chosen by the step
  assign prod = op_x * op_y;

  // magnitude of the numerator
  assign mag = acc_q[ProdW-1] ? ProdW'(-acc_q) : ProdW'(acc_q);

  // one restoring division step
  assign trial    = {rem_q, lo_q[SampleW-1]};
  assign fits     = (trial >= {1'b0, req_i.d});
  assign rem_next = fits ? RateW'(trial - {1'b0, req_i.d}) : trial[RateW-1:0];
  assign lo_next  = {lo_q[SampleW-2:0], fits};

  // step sequencing
  always_comb begin
    st_d   = st_q;
    acc_d  = acc_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quot_d = quot_q;
    op_x   = {req_i.a[SampleW-1], req_i.a};
    op_y   = $signed({1'b0, req_i.d});
    unique case (st_q)
      A_IDLE: begin
        // a * d
        if (req_i.start) begin
          acc_d = prod;
          st_d  = A_MULB;
        end
      end
      A_MULB: begin
        // + (b - a) * r
        op_x  = $signed({req_i.b[SampleW-1], req_i.b}) - $signed({req_i.a[SampleW-1], req_i.a});
        op_y  = $signed({1'b0, req_i.r});
        acc_d = acc_q + prod;
        st_d  = A_ABS;
      end
      A_ABS: begin
        // upper part is already below the divisor
        neg_d = acc_q[ProdW-1];
        rem_d = mag[SampleW +: RateW];
        lo_d  = mag[SampleW-1:0];
        cnt_d = lirs_pkg::DivCntW'(lirs_pkg::DivSteps - 1);
        st_d  = A_DIV;
      end
      A_DIV: begin
        rem_d = rem_next;
        lo_d  = lo_next;
        if (cnt_q == '0) begin
          done_d = 1'b1;
          quot_d = neg_q ? lirs_pkg::sample_t'(-lo_next) : lirs_pkg::sample_t'(lo_next);
          st_d   = A_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: st_d = A_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= A_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    neg_q  <= neg_d;
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    cnt_q  <= cnt_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

[hw/rtl/lirs_seq.sv]
// sequencer: stream state, phase walk, one-deep result hold and output register
module lirs_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lirs_pkg::sample_t    sample_in_i,
  input  logic                 end_of_stream_i,
  input  lirs_pkg::rate_t      src_rate_i,
  input  lirs_pkg::rate_t      dst_rate_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lirs_pkg::sample_t    sample_out_o,
  output logic                 last_of_run_o,
  output logic                 stream_done_o,
  output lirs_pkg::arith_req_t arith_req_o,
  input  lirs_pkg::arith_rsp_t arith_rsp_i
);

  localparam int unsigned PhaseW = lirs_pkg::PhaseW;
  localparam int unsigned RateW  = lirs_pkg::RateW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LCHK  = 3'd1;
  localparam logic [2:0] S_BLEND = 3'd2;
  localparam logic [2:0] S_PUSH  = 3'd3;
  localparam logic [2:0] S_TCHK  = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]        st_q, st_d;
  lirs_pkg::sample_t x_q, x_d;
  logic              eos_q, eos_d;
  lirs_pkg::sample_t prev_q, prev_d;
  logic              have_q, have_d;
  lirs_pkg::phase_t  phase_q, phase_d;
  lirs_pkg::phase_t  ph_q, ph_d;
  lirs_pkg::count_t  n_q, n_d;
  lirs_pkg::sample_t res_q, res_d;
  lirs_pkg::sample_t pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;
  logic              ret_tail_q, ret_tail_d;
  logic              out_vld_q;
  lirs_pkg::sample_t out_data_q;
  logic              out_last_q, out_done_q;

  logic              out_free;
  logic              out_load;
  logic              load_last, load_done;
  logic              ph_lt, n_ok;
  lirs_pkg::phase_t  ph_inc, new_phase;

  assign in_ready_o = (st_q == S_IDLE);
  assign out_free   = !out_vld_q || out_ready_i;

  // phase compares and steps
  assign ph_lt     = (ph_q < PhaseW'(dst_rate_i));
  assign n_ok      = (n_q < lirs_pkg::CountW'(lirs_pkg::ResultCap));
  assign ph_inc    = ph_q + PhaseW'(src_rate_i);
  assign new_phase = ph_lt ? '0 : ph_q - PhaseW'(dst_rate_i);

  // request to the shared unit
  assign arith_req_o.start = (st_q == S_LCHK) && ph_lt && n_ok;
  assign arith_req_o.a     = prev_q;
  assign arith_req_o.b     = x_q;
  assign arith_req_o.r     = ph_q[RateW-1:0];
  assign arith_req_o.d     = dst_rate_i;

  // main sequencer
  always_comb begin
    st_d       = st_q;
    x_d        = x_q;
    eos_d      = eos_q;
    prev_d     = prev_q;
    have_d     = have_q;
    phase_d    = phase_q;
    ph_d       = ph_q;
    n_d        = n_q;
    res_d      = res_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    ret_tail_d = ret_tail_q;
    out_load   = 1'b0;
    load_last  = 1'b0;
    load_done  = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d   = sample_in_i;
          eos_d = end_of_stream_i;
          n_d   = '0;
          if (src_rate_i == dst_rate_i) begin
            // equal rates: straight through
            pend_d     = sample_in_i;
            pend_vld_d = 1'b1;
            st_d       = S_FLUSH;
            if (end_of_stream_i) begin
              prev_d  = '0;
              have_d  = 1'b0;
              phase_d = '0;
            end else begin
              prev_d  = sample_in_i;
              have_d  = 1'b1;
              phase_d = PhaseW'(dst_rate_i);
            end
          end else if (!have_q) begin
            // first sample is only stored
            have_d = 1'b1;
            prev_d = sample_in_i;
            ph_d   = phase_q;
            st_d   = end_of_stream_i ? S_TCHK : S_IDLE;
          end else begin
            ph_d = phase_q;
            st_d = S_LCHK;
          end
        end
      end
      S_LCHK: begin
        if (ph_lt && n_ok) begin
          st_d = S_BLEND;
        end else begin
          // span done, keep phase for the next sample
          phase_d = new_phase;
          prev_d  = x_q;
          if (eos_q) begin
            ph_d = new_phase;
            st_d = S_TCHK;
          end else begin
            st_d = S_FLUSH;
          end
        end
      end
      S_BLEND: begin
        if (arith_rsp_i.done) begin
          res_d      = arith_rsp_i.quot;
          ph_d       = ph_inc;
          n_d        = n_q + 1'b1;
          ret_tail_d = 1'b0;
          st_d       = S_PUSH;
        end
      end
      S_PUSH: begin
        // older held result goes out, new one is held
        if (!pend_vld_q) begin
          pend_d     = res_q;
          pend_vld_d = 1'b1;
          st_d       = ret_tail_q ? S_TCHK : S_LCHK;
        end else if (out_free) begin
          out_load = 1'b1;
          pend_d   = res_q;
          st_d     = ret_tail_q ? S_TCHK : S_LCHK;
        end
      end
      S_TCHK: begin
        // tail past the last sample repeats it
        if (ph_lt && n_ok) begin
          res_d      = x_q;
          ph_d       = ph_inc;
          n_d        = n_q + 1'b1;
          ret_tail_d = 1'b1;
          st_d       = S_PUSH;
        end else begin
          prev_d  = '0;
          have_d  = 1'b0;
          phase_d = '0;
          st_d    = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // held result is the final one of this input
        if (!pend_vld_q) begin
          st_d = S_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          load_last  = 1'b1;
          load_done  = eos_q;
          pend_vld_d = 1'b0;
          st_d       = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      prev_q     <= '0;
      have_q     <= 1'b0;
      phase_q    <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      st_q       <= st_d;
      prev_q     <= prev_d;
      have_q     <= have_d;
      phase_q    <= phase_d;
      pend_vld_q <= pend_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    eos_q      <= eos_d;
    ph_q       <= ph_d;
    n_q        <= n_d;
    res_q      <= res_d;
    pend_q     <= pend_d;
    ret_tail_q <= ret_tail_d;
    if (out_load) begin
      out_data_q <= pend_q;
      out_last_q <= load_last;
      out_done_q <= load_done;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign sample_out_o  = out_data_q;
  assign last_of_run_o = out_last_q;
  assign stream_done_o = out_done_q;

endmodule

[dv/lirs_stream_checker.sv]
// stream checker of the resampler: predicts the output samples and compares each transfer
module lirs_stream_checker
  import lirs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  sample_t  sample_in_i,
  input  logic     end_of_stream_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  sample_t  sample_out_i,
  input  logic     last_of_run_i,
  input  logic     stream_done_i,
  input  logic     cfg_we_i,
  input  cfg_idx_t cfg_idx_i,
  input  rate_t    cfg_data_i,
  output int       outstanding_o,
  output int       mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sample_t value;
    logic    last;
    logic    done;
  } resampled_t;

  resampled_t expected_q[$];

  // own copy of the rate registers and the stream state
  rate_t   src_rate_q;
  rate_t   dst_rate_q;
  sample_t held_sample;
  logic    held_valid;
  phase_t  phase_acc;

  // exact weighted mean of a neighbouring pair, truncated toward zero
  function automatic sample_t weighted_mean(sample_t a, sample_t b, int unsigned r,
                                            int unsigned d);
    longint num;
    num = longint'(a) * longint'(d - r) + longint'(b) * longint'(r);
    return sample_t'(num / longint'(d));
  endfunction

  task automatic clear_stream();
    held_sample = '0;
    held_valid  = 1'b0;
    phase_acc   = '0;
  endtask

  // works out every sample that one input transfer causes and queues them
  task automatic predict_outputs(input sample_t x, input logic eos);
    sample_t     vals [ResultCap];
    int unsigned sr;
    int unsigned dr;
    int unsigned ph;
    int          n;
    resampled_t  item;
    sr = (src_rate_q == '0) ? 1 : src_rate_q;
    dr = (dst_rate_q == '0) ? 1 : dst_rate_q;
    n  = 0;
    if (sr == dr) begin
      // equal rates: straight through, next output sits on the next sample
      vals[0] = x;
      n = 1;
      if (eos) begin
        clear_stream();
      end else begin
        held_sample = x;
        held_valid  = 1'b1;
        phase_acc   = phase_t'(dr);
      end
    end else begin
      // outputs between the held sample and this one
      if (!held_valid) begin
        held_valid = 1'b1;
      end else begin
        ph = phase_acc;
        while (ph < dr && n < ResultCap) begin
          vals[n] = weighted_mean(held_sample, x, ph, dr);
          n++;
          ph += sr;
        end
        phase_acc = (ph >= dr) ? phase_t'(ph - dr) : '0;
      end
      held_sample = x;
      // tail of the stream repeats the final sample
      if (eos) begin
        ph = phase_acc;
        while (ph < dr && n < ResultCap) begin
          vals[n] = x;
          n++;
          ph += sr;
        end
        clear_stream();
      end
    end
    for (int k = 0; k < n; k++) begin
      item.value = vals[k];
      item.last  = (k == n - 1);
      item.done  = (k == n - 1) && eos;
      expected_q.push_back(item);
    end
  endtask

  task automatic note_mismatch();
    mismatches_o = mismatches_o + 1;
  endtask

  // compares one output transfer with the oldest expectation
  task automatic check_output();
    resampled_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected output, expected none, got sample %0d last %0b done %0b",
               $time, sample_out_i, last_of_run_i, stream_done_i);
      note_mismatch();
    end else begin
      want = expected_q.pop_front();
      if (want.value !== sample_out_i || want.last !== last_of_run_i ||
          want.done !== stream_done_i) begin
        if (want.value !== sample_out_i)
          $display("%0t: sample_out expected %0d got %0d", $time, want.value, sample_out_i);
        if (want.last !== last_of_run_i)
          $display("%0t: last_of_run expected %0b got %0b", $time, want.last,
                   last_of_run_i);
        if (want.done !== stream_done_i)
          $display("%0t: stream_done expected %0b got %0b", $time, want.done,
                   stream_done_i);
        note_mismatch();
      end
    end
  endtask

  // register writes, then input transfers, then output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_rate_q = SrcRateRst;
      dst_rate_q = DstRateRst;
      clear_stream();
      expected_q.delete();
      outstanding_o <= 0;
      mismatches_o  = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgSrcRate) src_rate_q = cfg_data_i;
        else if (cfg_idx_i == CfgDstRate) dst_rate_q = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) predict_outputs(sample_in_i, end_of_stream_i);
      if (out_valid_i && out_ready_i) check_output();
      outstanding_o <= expected_q.size();
    end
  end

endmodule

[dv/tb_linear_interp_resampler_top.sv]
// testbench top of the resampler: clock, reset, stimulus, idling and the verdict
module tb_linear_interp_resampler_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lirs_pkg::*;

  // cycles without any transfer before the run is abandoned
  localparam int StallLimit   = 4000;
  // settling time for an input that yields no output
  localparam int SettleCycles = 40;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  sample_t  sample_in = '0;
  logic     eos_in = 1'b0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sample_t  sample_out;
  logic     last_of_run;
  logic     stream_done;
  logic     cfg_we = 1'b0;
  cfg_idx_t cfg_idx = CfgSrcRate;
  rate_t    cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int outstanding;
  int mismatches;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  linear_interp_resampler_top uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .sample_in_i     (sample_in),
    .end_of_stream_i (eos_in),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .sample_out_o    (sample_out),
    .last_of_run_o   (last_of_run),
    .stream_done_o   (stream_done),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  lirs_stream_checker u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .sample_in_i     (sample_in),
    .end_of_stream_i (eos_in),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .sample_out_i    (sample_out),
    .last_of_run_i   (last_of_run),
    .stream_done_i   (stream_done),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .outstanding_o   (outstanding),
    .mismatches_o    (mismatches)
  );

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_sample(input sample_t x, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    eos_in    <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and wait until every expected sample has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // writes both rate registers on consecutive edges
  task automatic set_rates(input rate_t src, input rate_t dst);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgSrcRate;
    cfg_data <= src;
    @(posedge clk);
    cfg_idx  <= CfgDstRate;
    cfg_data <= dst;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // common audio rates, mixed with arbitrary ones
  function automatic rate_t pick_rate();
    case ($urandom_range(9))
      0:       return 18'd8000;
      1:       return 18'd11025;
      2:       return 18'd16000;
      3:       return 18'd22050;
      4:       return 18'd44100;
      5:       return 18'd48000;
      6:       return 18'd96000;
      7:       return 18'd192000;
      8:       return rate_t'($urandom_range(2000, 1));
      default: return rate_t'($urandom_range(192000, 1));
    endcase
  endfunction

  initial begin
    rate_t   src;
    rate_t   dst;
    sample_t x;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset rates, downsampling: single-sample stream, stream without tail, extremes
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'shFFFF, 1'b0);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    wait_idle();

    // equal rates, stream left open
    set_rates(18'd48000, 18'd48000);
    send_sample(16'sh1234, 1'b0);
    send_sample(16'sh8000, 1'b0);
    wait_idle();

    // rates changed mid-stream after pass-through
    set_rates(18'd48000, 18'd96000);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'shC000, 1'b0);
    send_sample(16'sh4000, 1'b1);
    wait_idle();

    // zero rates read as one, so equal
    set_rates(18'd0, 18'd0);
    send_sample(16'sh5A5A, 1'b1);
    wait_idle();

    // zero source rate against a small destination rate
    set_rates(18'd0, 18'd5);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh0101, 1'b1);
    wait_idle();

    // far beyond the upsampling limit: result cap
    set_rates(18'd1, 18'd192000);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'shA5A5, 1'b1);
    wait_idle();

    // extreme downsampling
    set_rates(18'd192000, 18'd1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh3333, 1'b1);
    wait_idle();

    // random streams over random rates, idling mode rotating per chunk
    for (int chunk = 0; chunk < 8; chunk++) begin
      case (chunk % 4)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= 69;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 69;
        end
        default: begin
          send_idle_pct  <= 18;
          recv_stall_pct <= 18;
        end
      endcase
      src = pick_rate();
      dst = ($urandom_range(5) == 0) ? src : pick_rate();
      // mostly keep within the supported upsampling ratio
      if (dst > 16 * src && $urandom_range(3) != 0) dst = rate_t'(16 * src);
      set_rates(src, dst);
      for (int i = 0; i < 10; i++) begin
        case ($urandom_range(7))
          0:       x = 16'sh8000;
          1:       x = 16'sh7FFF;
          default: x = sample_t'($urandom);
        endcase
        send_sample(x, ($urandom_range(5) == 0));
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
